// ===== sv/blp_pkg.sv =====
`default_nettype none

package blp_pkg;

  localparam int STEP_DEPTH_DEF = 16;
  localparam int MAX_TERMS_DEF  = 32;

  localparam int CUR_W   = 20;
  localparam int START_W = 32;
  localparam int DUR_W   = 24;
  localparam int ALPHA_W = 40;
  localparam int BETA_W  = 24;
  localparam int NT_W    = 6;
  localparam int DELTA_W = 16;
  localparam int LIFE_W  = 32;
  localparam int SOC_W   = 15;
  localparam int Y_W     = 64;

  // Scan times and step offsets, wide enough for start plus duration plus one increment.
  localparam int T_W     = 34;
  // Series coefficient as seen by the exponential unit and the divider.
  localparam int KX_W    = 40;
  localparam int EXP_W   = 25;
  localparam int ROM_W   = 33;
  localparam int ROM_N   = 257;

  localparam int DVD_W   = 55;
  localparam int DVS_W   = 40;
  localparam int ITER_W  = $clog2(DVD_W + 1);
  localparam int TQ_W    = 29;

  localparam logic [SOC_W-1:0]   SOC_FULL = 15'd25600;
  localparam logic [ALPHA_W-1:0] MASK40   = {ALPHA_W{1'b1}};

  typedef enum logic [1:0] {
    REG_ALPHA     = 2'd0,
    REG_BETA_SQ   = 2'd1,
    REG_NUM_TERMS = 2'd2,
    REG_DELTA     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             done;
    logic [EXP_W-1:0] value;
  } exp_rsp_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quo;
  } div_rsp_t;

  typedef logic [ROM_W-1:0] rom_t [ROM_N];

  // exp(-i/16) in Q1.32, built by a truncated Taylor series and rounded products.
  function automatic rom_t build_exp_rom();
    rom_t        r;
    logic [63:0] t [ROM_N];
    logic [63:0] term;
    logic [63:0] s;
    t[0] = 64'd1 << 32;
    for (int j = 1; j <= 16; j++) begin
      term = 64'd1 << 56;
      s    = term;
      for (int n = 1; n <= 24; n++) begin
        term = (term * 64'(j)) / 64'(16 * n);
        if (n[0]) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
      t[j] = (s + (64'd1 << 23)) >> 24;
    end
    for (int n = 2; n <= 16; n++) begin
      t[16 * n] = (t[16 * (n - 1)] * t[16] + (64'd1 << 31)) >> 32;
    end
    for (int n = 1; n < 16; n++) begin
      for (int j = 1; j < 16; j++) begin
        t[16 * n + j] = (t[16 * n] * t[j] + (64'd1 << 31)) >> 32;
      end
    end
    for (int i = 0; i < ROM_N; i++) begin
      r[i] = t[i][ROM_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

// ===== sv/battery_lifetime_predictor_top.sv =====
// Channel      | Direction | Payload
// -------------+-----------+------------------------------------------------------------
// s_axis       | in        | tdata: load_current[19:0], step_start[51:20], duration[75:52]
// m_axis       | out       | tdata: lifetime[31:0], soc_percent[46:32]; tuser: exhausted,
//              |           |        history_full
// APB          | in/out    | alpha @0x00, beta_sq @0x08, series terms @0x10, delta @0x18
//
// One load step is handled at a time. Per scan point, each stored step takes, per term,
// two passes of the exponential unit and a 29-bit quotient from the serial divider (neither
// when beta_sq is zero); each scan point ends with a threshold check, and the state of
// charge may take one more quotient from the divider.
// Reset is asynchronous and active low; the store itself needs no clearing. A result
// waits in the output register while the block goes back to accepting steps.
`default_nettype none

module battery_lifetime_predictor_top
  import blp_pkg::*;
#(
  parameter int STEP_DEPTH = STEP_DEPTH_DEF,
  parameter int MAX_TERMS  = MAX_TERMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // load_current[19:0], step_start[51:20], duration[75:52], zero fill[79:76]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // lifetime[31:0], soc_percent[46:32], zero fill[47]
  output logic [47:0]      m_axis_tdata,
  // exhausted[0], history_full[1]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int AW    = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
  localparam int CNT_W = $clog2(STEP_DEPTH + 1);
  localparam int M_W   = $clog2(MAX_TERMS + 1);
  localparam int K_W   = BETA_W + 2 * M_W;
  localparam int S_W   = T_W + M_W;
  localparam int BR_W  = S_W + 2;
  localparam int LO_W  = BR_W / 2;
  localparam int MEM_W = CUR_W + START_W + DUR_W;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_RD       = 16'h0002,
    ST_SETUP    = 16'h0004,
    ST_TERM     = 16'h0008,
    ST_EXP_E    = 16'h0010,
    ST_EXP_A    = 16'h0020,
    ST_DIV      = 16'h0040,
    ST_NEXT     = 16'h0080,
    ST_MUL_LO   = 16'h0100,
    ST_MUL_HI   = 16'h0200,
    ST_ACC      = 16'h0400,
    ST_CHECK    = 16'h0800,
    ST_SOC_INIT = 16'h1000,
    ST_SOC_CMP  = 16'h2000,
    ST_SOC_DIV  = 16'h4000,
    ST_FIN      = 16'h8000
  } state_e;

  // Configuration registers.
  logic [ALPHA_W-1:0] alpha_q;
  logic [BETA_W-1:0]  beta_q;
  logic [NT_W-1:0]    nterms_q;
  logic [DELTA_W-1:0] delta_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= '0;
      beta_q   <= '0;
      nterms_q <= NT_W'(10);
      delta_q  <= DELTA_W'(26);
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[4:3]))
        REG_ALPHA:     alpha_q  <= pwdata[ALPHA_W-1:0];
        REG_BETA_SQ:   beta_q   <= pwdata[BETA_W-1:0];
        REG_NUM_TERMS: nterms_q <= pwdata[NT_W-1:0];
        REG_DELTA:     delta_q  <= pwdata[DELTA_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:3]))
      REG_ALPHA:     prdata = 64'(alpha_q);
      REG_BETA_SQ:   prdata = 64'(beta_q);
      REG_NUM_TERMS: prdata = 64'(nterms_q);
      REG_DELTA:     prdata = 64'(delta_q);
      default:       prdata = '0;
    endcase
  end

  // Control and datapath state.
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, i_q, i_d;
  logic [T_W-1:0]     now_q, now_d, end_q, end_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [T_W-1:0]     a_q, a_d, e_q, e_d, lin_q, lin_d;
  logic [S_W-1:0]     s_q, s_d;
  logic [M_W-1:0]     m_q, m_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [EXP_W-1:0]   ee_q, ee_d;
  logic [63:0]        prod_q, prod_d;
  logic [Y_W-1:0]     y_q, y_d;
  logic [LIFE_W-1:0]  life_q, life_d;
  logic               exh_q, exh_d, first_q, first_d, hfull_q, hfull_d;
  logic [ALPHA_W-1:0] lower_q, lower_d, span_q, span_d;
  logic [SOC_W-1:0]   soc_q, soc_d;

  logic               mv_q, mv_d;
  logic [LIFE_W-1:0]  o_life_q, o_life_d;
  logic [SOC_W-1:0]   o_soc_q, o_soc_d;
  logic               o_exh_q, o_exh_d, o_hf_q, o_hf_d;

  // Step store: entry i holds {duration, step start, load_current}.
  logic [MEM_W-1:0]   mem_q [STEP_DEPTH];
  logic [MEM_W-1:0]   rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;

  logic               in_acc, full;
  logic [CUR_W-1:0]   in_cur;
  logic [START_W-1:0] in_start;
  logic [DUR_W-1:0]   in_dur;
  logic [M_W-1:0]     terms;
  logic [DELTA_W-1:0] inc;
  logic [CUR_W-1:0]   r_cur;
  logic [T_W-1:0]     r_start, r_end;
  logic [BR_W-1:0]    br;
  logic [ALPHA_W-1:0] ysat, soc_n;
  logic [44:0]        soc_n25;
  logic [EXP_W-1:0]   d_diff;

  logic               exp_start, div_start, div_soc;
  logic [T_W-1:0]     exp_t;
  exp_rsp_t           exp_rsp;
  div_rsp_t           div_rsp;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [ITER_W-1:0]  div_iters;

  assign in_cur   = s_axis_tdata[19:0];
  assign in_start = s_axis_tdata[51:20];
  assign in_dur   = s_axis_tdata[75:52];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CNT_W'(STEP_DEPTH));
  assign mem_we        = in_acc && !full;
  assign mem_waddr     = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= {in_dur, in_start, in_cur};
    end
    rd_q <= mem_q[i_q[AW-1:0]];
  end

  assign terms = (32'(nterms_q) > MAX_TERMS) ? M_W'(MAX_TERMS) : M_W'(nterms_q);
  assign inc   = (delta_q == '0) ? DELTA_W'(1) : delta_q;

  always_comb begin
    r_cur   = rd_q[CUR_W-1:0];
    r_start = T_W'(rd_q[CUR_W+START_W-1:CUR_W]);
    r_end   = r_start + T_W'(rd_q[MEM_W-1:CUR_W+START_W]);
    br      = BR_W'(lin_q) + (BR_W'(s_q) << 1);
    ysat    = (y_q[Y_W-1:ALPHA_W] != '0) ? MASK40 : y_q[ALPHA_W-1:0];
    soc_n   = (ysat > lower_q) ? ysat - lower_q : '0;
    soc_n25 = 45'({soc_n, 4'b0}) + 45'({soc_n, 3'b0}) + 45'(soc_n);
    d_diff  = (ee_q > exp_rsp.value) ? ee_q - exp_rsp.value : '0;
  end

  // Shared units: exponential evaluator and serial divider.
  assign exp_t = (state_q == ST_EXP_E) ? a_q : e_q;

  blp_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .k_i     (KX_W'(k_q)),
    .t_i     (exp_t),
    .rsp_o   (exp_rsp)
  );

  assign div_soc   = (state_q == ST_SOC_CMP);
  assign div_dvd   = div_soc ? {soc_n25, 10'b0}
                             : (DVD_W'({d_diff, 4'b0}) << (DVD_W - TQ_W));
  assign div_dvs   = div_soc ? span_q : DVS_W'(k_q);
  assign div_iters = div_soc ? ITER_W'(DVD_W) : ITER_W'(TQ_W);

  blp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .iters_i    (div_iters),
    .rsp_o      (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    now_d     = now_q;
    end_d     = end_q;
    cur_d     = cur_q;
    a_d       = a_q;
    e_d       = e_q;
    lin_d     = lin_q;
    s_d       = s_q;
    m_d       = m_q;
    k_d       = k_q;
    ee_d      = ee_q;
    prod_d    = prod_q;
    y_d       = y_q;
    life_d    = life_q;
    exh_d     = exh_q;
    first_d   = first_q;
    hfull_d   = hfull_q;
    lower_d   = lower_q;
    span_d    = span_q;
    soc_d     = soc_q;
    exp_start = 1'b0;
    div_start = 1'b0;
    mv_d      = mv_q;
    o_life_d  = o_life_q;
    o_soc_d   = o_soc_q;
    o_exh_d   = o_exh_q;
    o_hf_d    = o_hf_q;

    if (mv_q && m_axis_tready) begin
      mv_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hfull_d = full;
          now_d   = T_W'(in_start);
          end_d   = T_W'(in_start) + T_W'(in_dur);
          i_d     = '0;
          y_d     = '0;
          if (!full) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (full || exh_q) begin
            state_d = ST_FIN;
          end else if (in_dur != '0) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_SOC_INIT;
          end
        end
      end
      ST_RD: begin
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        // Offsets of the scan time from the stored step's start and end.
        cur_d = r_cur;
        a_d   = (now_q > r_start) ? now_q - r_start : '0;
        e_d   = (now_q > r_end) ? now_q - r_end : '0;
        lin_d = a_d - e_d;
        s_d   = '0;
        m_d   = M_W'(1);
        k_d   = K_W'(beta_q);
        state_d = (terms == '0) ? ST_MUL_LO : ST_TERM;
      end
      ST_TERM: begin
        if (k_q == '0) begin
          s_d     = s_q + S_W'(lin_q);
          state_d = ST_NEXT;
        end else begin
          exp_start = 1'b1;
          state_d   = ST_EXP_E;
        end
      end
      ST_EXP_E: begin
        if (exp_rsp.done) begin
          ee_d      = exp_rsp.value;
          exp_start = 1'b1;
          state_d   = ST_EXP_A;
        end
      end
      ST_EXP_A: begin
        if (exp_rsp.done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          s_d     = s_q + S_W'(div_rsp.quo[TQ_W-1:0]);
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (m_q == terms) begin
          state_d = ST_MUL_LO;
        end else begin
          // beta*(m+1)^2 = beta*m^2 + beta*(2m+1)
          k_d     = k_q + K_W'(beta_q) * K_W'({m_q, 1'b1});
          m_d     = m_q + M_W'(1);
          state_d = ST_TERM;
        end
      end
      ST_MUL_LO: begin
        prod_d  = 64'(cur_q) * 64'(br[LO_W-1:0]);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        prod_d  = prod_q + ((64'(cur_q) * 64'(br[BR_W-1:LO_W])) << LO_W);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        y_d = y_q + (prod_q >> 8);
        i_d = i_q + CNT_W'(1);
        state_d = (i_d == cnt_q) ? ST_CHECK : ST_RD;
      end
      ST_CHECK: begin
        if (y_q > Y_W'(alpha_q)) begin
          life_d  = (now_q[T_W-1:LIFE_W] != '0) ? '1 : now_q[LIFE_W-1:0];
          exh_d   = 1'b1;
          state_d = ST_SOC_INIT;
        end else begin
          now_d = now_q + T_W'(inc);
          if (now_d < end_q) begin
            i_d     = '0;
            y_d     = '0;
            state_d = ST_RD;
          end else begin
            state_d = ST_SOC_INIT;
          end
        end
      end
      ST_SOC_INIT: begin
        if (!first_q) begin
          lower_d = ysat;
          span_d  = (alpha_q > ysat) ? alpha_q - ysat : '0;
          first_d = 1'b1;
        end
        state_d = ST_SOC_CMP;
      end
      ST_SOC_CMP: begin
        if (soc_n >= span_q) begin
          soc_d   = SOC_FULL;
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_SOC_DIV;
        end
      end
      ST_SOC_DIV: begin
        if (div_rsp.done) begin
          soc_d   = div_rsp.quo[SOC_W-1:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hand the result to the output register once it is free.
        if (!mv_q || m_axis_tready) begin
          mv_d     = 1'b1;
          o_life_d = life_q;
          o_soc_d  = soc_q;
          o_exh_d  = exh_q;
          o_hf_d   = hfull_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      life_q  <= '0;
      exh_q   <= 1'b0;
      first_q <= 1'b0;
      lower_q <= '0;
      span_q  <= '0;
      soc_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      life_q  <= life_d;
      exh_q   <= exh_d;
      first_q <= first_d;
      lower_q <= lower_d;
      span_q  <= span_d;
      soc_q   <= soc_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    end_q    <= end_d;
    cur_q    <= cur_d;
    a_q      <= a_d;
    e_q      <= e_d;
    lin_q    <= lin_d;
    s_q      <= s_d;
    m_q      <= m_d;
    k_q      <= k_d;
    ee_q     <= ee_d;
    prod_q   <= prod_d;
    y_q      <= y_d;
    hfull_q  <= hfull_d;
    o_life_q <= o_life_d;
    o_soc_q  <= o_soc_d;
    o_exh_q  <= o_exh_d;
    o_hf_q   <= o_hf_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {1'b0, o_soc_q, o_life_q};
  assign m_axis_tuser  = {o_hf_q, o_exh_q};

`ifndef SYNTHESIS
  a_exh_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exh_q |=> exh_q)
    else $error("exhausted flag cleared");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= STEP_DEPTH)
    else $error("step count beyond store depth");

  a_soc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    soc_q <= SOC_FULL)
    else $error("state of charge out of range");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ===== sv/blp_exp.sv =====
`default_nettype none

module blp_exp
  import blp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [KX_W-1:0] k_i,
  input  wire logic [T_W-1:0]  t_i,
  output exp_rsp_t             rsp_o
);

  // Three stages: product, table interpolation, rounding.
  logic              v1_q, v2_q, v3_q;
  logic              zero1_q, ovf1_q, zero2_q, kill2_q;
  logic [63:0]       p1_q;
  logic [ROM_W-1:0]  hi2_q, sh2_q;
  logic [EXP_W-1:0]  res_q;

  logic [7:0]        idx;
  logic [19:0]       fr;
  logic [ROM_W-1:0]  hi, lo, diff;
  logic [52:0]       prod;
  logic [ROM_W-1:0]  v;
  logic [ROM_W:0]    vr;

  always_comb begin
    idx  = p1_q[31:24];
    fr   = p1_q[23:4];
    hi   = EXP_ROM[idx];
    lo   = EXP_ROM[9'(idx) + 9'd1];
    diff = (hi > lo) ? hi - lo : '0;
    prod = 53'(diff) * 53'(fr);
    v    = hi2_q - sh2_q;
    vr   = (ROM_W + 1)'(v) + (ROM_W + 1)'(128);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero1_q <= (t_i == '0);
      ovf1_q  <= (k_i[KX_W-1:32] != '0) || (t_i[T_W-1:32] != '0);
      p1_q    <= 64'(k_i[31:0]) * 64'(t_i[31:0]);
    end
    zero2_q <= zero1_q;
    kill2_q <= ovf1_q || (p1_q[63:32] != '0);
    hi2_q   <= hi;
    sh2_q   <= prod[52:20];
    if (zero2_q) begin
      res_q <= EXP_W'(1) << 24;
    end else if (kill2_q) begin
      res_q <= '0;
    end else begin
      res_q <= vr[EXP_W+7:8];
    end
  end

  assign rsp_o.done  = v3_q;
  assign rsp_o.value = res_q;

endmodule

`default_nettype wire

// ===== sv/blp_div.sv =====
`default_nettype none

module blp_div
  import blp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DVD_W-1:0]  dividend_i,
  input  wire logic [DVS_W-1:0]  divisor_i,
  input  wire logic [ITER_W-1:0] iters_i,
  output div_rsp_t               rsp_o
);

  // Restoring divider, one quotient bit per cycle; the dividend comes in left-aligned.
  logic              busy_q, done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [DVD_W-1:0]  dvd_q, quo_q;
  logic [DVS_W-1:0]  dvs_q, rem_q;
  logic [DVS_W:0]    rem_sh;
  logic              take;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    take   = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - ITER_W'(1);
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= take ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], take};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire
